>>> design/rtlpm_pkg.sv
// ----------------------------------------------------------------------------
// Route table LPM package
// Shared constants, codes and types for the route table and its parts.
// ----------------------------------------------------------------------------
package rtlpm_pkg;

	// Number of route slots in the table.
	localparam int TABLE_ENTRIES = 16;
	// Bits needed to address one slot.
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	// Width of the active route count on the result port.
	localparam int CNT_W = 5;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// Action codes.
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_DEL    = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_NOP    = 2'd3;

	// Status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;

	// Starting metric of a lookup: a route with mask zero must beat it.
	localparam logic [31:0] NO_METRIC = 32'hFFFF_FFFF;

	// Positions of the route flags.
	localparam int FLAG_UP      = 0;
	localparam int FLAG_GATEWAY = 1;
	localparam int FLAG_DEFAULT = 2;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [31:0] metric;
		logic [2:0]  flags;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Control from the sequencer to the match unit.
	typedef struct packed {
		logic clear;
		logic eval;
		logic is_del;
	} eval_ctl_t;

	// What the match unit has found so far.
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] found_idx;
		logic [31:0]      gateway;
	} eval_res_t;

endpackage

>>> design/rtlpm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rtlpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/rtlpm_eval.sv
// ----------------------------------------------------------------------------
// Route match unit
// Judges one table entry a cycle and keeps the best route or the first hit.
// ----------------------------------------------------------------------------
module rtlpm_eval
	import rtlpm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  eval_ctl_t        ctl,
	input  entry_t           entry,
	input  logic             entry_valid,
	input  logic [IDX_W-1:0] entry_idx,
	input  logic [31:0]      key_dest,
	input  logic [31:0]      key_mask,
	output eval_res_t        res
);

	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [31:0]      lead_mask_q;
	logic [31:0]      best_met_q;
	logic [31:0]      best_gw_q;

	logic del_hit;
	logic lpm_hit;

	// A delete wants an exact match on both destination and mask.
	assign del_hit = entry_valid && !found_q && (entry.dest == key_dest)
		&& (entry.mask == key_mask);

	// A lookup takes a longer mask, or a lower metric at an equal mask.
	assign lpm_hit = entry_valid && entry.flags[FLAG_UP]
		&& ((key_dest & entry.mask) == (entry.dest & entry.mask))
		&& ((entry.mask > lead_mask_q)
			|| ((entry.mask == lead_mask_q) && (entry.metric < best_met_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.eval && ctl.is_del && del_hit) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			lead_mask_q <= '0;
			best_met_q  <= NO_METRIC;
			best_gw_q   <= '0;
		end else if (ctl.eval) begin
			if (ctl.is_del) begin
				if (del_hit) begin
					found_idx_q <= entry_idx;
				end
			end else if (lpm_hit) begin
				lead_mask_q <= entry.mask;
				best_met_q  <= entry.metric;
				best_gw_q   <= entry.gateway;
			end
		end
	end

	assign res.found     = found_q;
	assign res.found_idx = found_idx_q;
	assign res.gateway   = best_gw_q;

endmodule

>>> design/route_table_lpm_core.sv
// ----------------------------------------------------------------------------
// Route table with longest prefix match
// Static table of TABLE_ENTRIES routes: add, delete and lookup operations.
// ----------------------------------------------------------------------------
// A word is taken at a rising edge where start is high and busy is low. An add
// or an unused action finishes at once: its result shows on the cycle after it
// was taken and busy never rises, so such words can follow one another every
// cycle. A delete or a lookup walks the whole table, one entry per cycle through
// the single read port of the route memory, and holds busy high through the
// scan state, which reads one slot at a time, the drain state, which judges the
// last entry behind the registered read, and the done state, which settles the
// result. Its result shows in the first cycle with busy low. Every result is on
// the ports for exactly one cycle, marked by done, and the receiver cannot hold
// it off, so it must take it then.
// Valid bits live in flip-flops and clear at reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module route_table_lpm_core
	import rtlpm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic [31:0]       dest_addr,
	input  logic [31:0]       net_mask,
	input  logic [31:0]       next_hop,
	input  logic [31:0]       route_metric,
	output logic              done,
	output logic [1:0]        status,
	output logic [31:0]       lookup_gateway,
	output logic [CNT_W-1:0]  active_routes
);

	state_t state_q, state_d;

	// Scan address and the read stage that follows the memory.
	logic [IDX_W-1:0] ridx_q;
	logic             rd_s1;
	logic [IDX_W-1:0] idx_s1;

	// The operation being scanned and its key.
	logic             is_del_q;
	logic [31:0]      key_dest_q;
	logic [31:0]      key_mask_q;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]         count_q;

	logic             done_q;
	logic [1:0]       status_q;
	logic [31:0]      gw_q;
	logic [CNT_W-1:0] routes_q;

	logic             accept;
	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic             ram_we;
	entry_t           wr_entry;
	entry_t           rd_entry;
	eval_ctl_t        ctl;
	eval_res_t        res;
	logic             scan_step;
	logic             finish;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// The lowest free slot takes a new route.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		wr_entry.dest    = dest_addr;
		wr_entry.mask    = net_mask;
		wr_entry.gateway = next_hop;
		wr_entry.metric  = route_metric;
		wr_entry.flags   = '0;
		wr_entry.flags[FLAG_UP]      = 1'b1;
		wr_entry.flags[FLAG_GATEWAY] = (next_hop != '0);
		wr_entry.flags[FLAG_DEFAULT] = (dest_addr == '0) && (net_mask == '0);
	end

	// An add writes the memory in the cycle it is taken. A scan starts no
	// earlier than the next cycle, so it always sees the new entry.
	assign ram_we = accept && (action == ACT_ADD) && free_found;

	rtlpm_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx),
		.wdata(wr_entry),
		.raddr(ridx_q),
		.rdata(rd_entry)
	);

	rtlpm_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.entry      (rd_entry),
		.entry_valid(valid_q[idx_s1]),
		.entry_idx  (idx_s1),
		.key_dest   (key_dest_q),
		.key_mask   (key_mask_q),
		.res        (res)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && ((action == ACT_DEL) || (action == ACT_LOOKUP))) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (ridx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State outputs. The match unit sees each entry in the cycle after its read.
	always_comb begin
		ctl.clear  = accept;
		ctl.eval   = rd_s1;
		ctl.is_del = is_del_q;
		scan_step  = 1'b0;
		finish     = 1'b0;
		case (state_q)
			ST_SCAN: begin
				scan_step = 1'b1;
			end
			ST_DONE: begin
				finish = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ridx_q  <= '0;
			rd_s1   <= 1'b0;
			valid_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= scan_step;
			if (accept) begin
				ridx_q <= '0;
			end else if (scan_step) begin
				ridx_q <= ridx_q + IDX_W'(1);
			end
			if (ram_we) begin
				valid_q[free_idx] <= 1'b1;
				count_q           <= count_q + CNT_W'(1);
			end else if (finish && is_del_q && res.found) begin
				valid_q[res.found_idx] <= 1'b0;
				count_q                <= count_q - CNT_W'(1);
			end
			done_q <= (accept && ((action == ACT_ADD) || (action == ACT_NOP))) || finish;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ridx_q;
		if (accept) begin
			is_del_q   <= (action == ACT_DEL);
			key_dest_q <= dest_addr;
			key_mask_q <= net_mask;
		end
		// Results: add and the unused action at once, a delete or a lookup at finish.
		if (accept && (action == ACT_ADD)) begin
			status_q <= free_found ? STAT_OK : STAT_FULL;
			gw_q     <= '0;
			routes_q <= free_found ? (count_q + CNT_W'(1)) : count_q;
		end else if (accept && (action == ACT_NOP)) begin
			status_q <= STAT_OK;
			gw_q     <= '0;
			routes_q <= count_q;
		end else if (finish) begin
			if (is_del_q) begin
				status_q <= res.found ? STAT_OK : STAT_NOTFOUND;
				gw_q     <= '0;
				routes_q <= res.found ? (count_q - CNT_W'(1)) : count_q;
			end else begin
				status_q <= STAT_OK;
				gw_q     <= res.gateway;
				routes_q <= count_q;
			end
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign lookup_gateway = gw_q;
	assign active_routes  = routes_q;

endmodule

>>> design/rtlpm_chk.sv
// ----------------------------------------------------------------------------
// Route table port checker
// Watches the ports of the route table and flags results that cannot occur.
// ----------------------------------------------------------------------------
module rtlpm_chk
	import rtlpm_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [1:0]       action,
	input logic             done,
	input logic [1:0]       status,
	input logic [31:0]      lookup_gateway,
	input logic [CNT_W-1:0] active_routes
);

	// An add or an unused action answers on the next cycle without going busy.
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((action == ACT_ADD) || (action == ACT_NOP))
		|=> done && !busy)
		else $error("add or unused action did not answer on the next cycle");

	// A delete or a lookup starts a scan and gives no result right away.
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((action == ACT_DEL) || (action == ACT_LOOKUP))
		|=> busy && !done)
		else $error("delete or lookup did not start a scan");

	// A full table reports every slot in use.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STAT_FULL) |-> active_routes == CNT_W'(TABLE_ENTRIES))
		else $error("table full reported with free slots");

	// A failed operation never carries a gateway.
	a_fail_no_gw: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STAT_OK) |-> lookup_gateway == '0)
		else $error("gateway on a failed operation");

	// The status code is always a defined one.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STAT_OK) || (status == STAT_FULL) || (status == STAT_NOTFOUND))
		else $error("undefined status code");

endmodule

bind route_table_lpm_core rtlpm_chk u_rtlpm_chk (.*);
